>>> hw/rtl/fragment_color_blend_core_macros.svh
// Assertion macros shared by the fragment colour blend checker.
// No dependencies; include by bare file name.
`ifndef FRAGMENT_COLOR_BLEND_CORE_MACROS_SVH
`define FRAGMENT_COLOR_BLEND_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define FCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define FCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fcb_pkg.sv
`timescale 1ns / 1ps
// Types, register map and helper functions for the fragment colour blend core.
// No dependencies.
package fcb_pkg;

    localparam int ADDR_W = 5;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_TINT_RED   = 3'd0;
    localparam logic [2:0] REG_TINT_GREEN = 3'd1;
    localparam logic [2:0] REG_TINT_BLUE  = 3'd2;
    localparam logic [2:0] REG_TINT_ALPHA = 3'd3;
    localparam logic [2:0] REG_BLEND_MODE = 3'd4;

    localparam logic [1:0] MODE_OPAQUE   = 2'd0;
    localparam logic [1:0] MODE_ALPHA    = 2'd1;
    localparam logic [1:0] MODE_ADDITIVE = 2'd2;
    localparam logic [1:0] MODE_MULTIPLY = 2'd3;

    localparam logic [15:0] ROUND_BIAS = 16'd127;
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    typedef struct packed {
        logic [7:0] texel_red;
        logic [7:0] texel_green;
        logic [7:0] texel_blue;
        logic [7:0] texel_alpha;
        logic [7:0] dest_red;
        logic [7:0] dest_green;
        logic [7:0] dest_blue;
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } t_frag_in;

    typedef struct packed {
        logic       write_enable;
        logic [9:0] out_x;
        logic [9:0] out_y;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_frag_out;

    typedef struct packed {
        logic [7:0] tint_red;
        logic [7:0] tint_green;
        logic [7:0] tint_blue;
        logic [7:0] tint_alpha;
        logic [1:0] blend_mode;
    } t_cfg;

    // channel index 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [2:0][7:0] src;
        logic [7:0]      alpha;
        logic [2:0][7:0] dest;
        logic [9:0]      x;
        logic [9:0]      y;
        logic            keep;
    } t_tinted;

    typedef struct packed {
        logic [2:0][7:0] eff;
        logic [7:0]      alpha;
        logic [2:0][7:0] dest;
        logic [9:0]      x;
        logic [9:0]      y;
        logic            keep;
    } t_effect;

    // Exact floor(x / 255) for any 16-bit x below 65280, where the result fits 8 bits.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

    // a * b + 127, always below 2^16
    function automatic logic [15:0] mul_bias(input logic [7:0] a, input logic [7:0] b);
        return ({8'h00, a} * {8'h00, b}) + ROUND_BIAS;
    endfunction

endpackage

>>> hw/rtl/fragment_color_blend_core.sv
`timescale 1ns / 1ps
// Top level of the fragment colour blend core: config registers and six-stage pipe.
// Depends on fcb_pkg, fcb_tint, fcb_effect, fcb_mix.
//
//  channel   signals                              direction  payload
//  --------  -----------------------------------  ---------  -----------------
//  in        i_in_valid / o_in_ready              sink       t_frag_in
//  out       o_out_valid / i_out_ready            source     t_frag_out
//  cfg       psel penable pwrite paddr pwdata     APB slave  5 regs at 4*i
//            prdata pready
//
// Six register stages: an accepted fragment passes through all six before it is offered
// at the output; one item per cycle sustained while the output is not stalled.
// Stages: tint multiply, /255 + clip, effect, /255, mix products, sum /255 + select.
// Each stage has its own valid bit and moves when the stage after it is empty or
// moving, so bubbles close up under a stall and nothing is dropped or repeated.
// Synchronous active-low reset clears valid bits and loads the register defaults
// (tint 255 on all channels, opaque mode). No clearing pass is needed.
module fragment_color_blend_core #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // fragment in
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  fcb_pkg::t_frag_in          i_in_item,
    // write request out
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output fcb_pkg::t_frag_out         o_out_item,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fcb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import fcb_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers. The user must write them only while the pipe
    // is idle (the block does not enforce it), so the stages read them directly.
    // ---------------------------------------------------------------
    t_cfg r_cfg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tint_red   <= FULL_SCALE;
            r_cfg.tint_green <= FULL_SCALE;
            r_cfg.tint_blue  <= FULL_SCALE;
            r_cfg.tint_alpha <= FULL_SCALE;
            r_cfg.blend_mode <= MODE_OPAQUE;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_TINT_RED:   r_cfg.tint_red   <= pwdata[7:0];
                REG_TINT_GREEN: r_cfg.tint_green <= pwdata[7:0];
                REG_TINT_BLUE:  r_cfg.tint_blue  <= pwdata[7:0];
                REG_TINT_ALPHA: r_cfg.tint_alpha <= pwdata[7:0];
                REG_BLEND_MODE: r_cfg.blend_mode <= pwdata[1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_TINT_RED:   prdata = {24'd0, r_cfg.tint_red};
            REG_TINT_GREEN: prdata = {24'd0, r_cfg.tint_green};
            REG_TINT_BLUE:  prdata = {24'd0, r_cfg.tint_blue};
            REG_TINT_ALPHA: prdata = {24'd0, r_cfg.tint_alpha};
            REG_BLEND_MODE: prdata = {30'd0, r_cfg.blend_mode};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline segments, two stages each
    // ---------------------------------------------------------------
    t_tinted tint_item;
    t_effect eff_item;
    logic    tint_valid, tint_ready;
    logic    eff_valid, eff_ready;

    fcb_tint #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_tint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (tint_valid),
        .i_ready (tint_ready),
        .o_item  (tint_item)
    );

    // saturating add / rounded multiply / pass-through
    fcb_effect u_effect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_cfg.blend_mode),
        .i_valid (tint_valid),
        .o_ready (tint_ready),
        .i_item  (tint_item),
        .o_valid (eff_valid),
        .i_ready (eff_ready),
        .o_item  (eff_item)
    );

    // alpha mix, opaque bypass, zero-alpha / clip blanking
    fcb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_cfg.blend_mode),
        .i_valid (eff_valid),
        .o_ready (eff_ready),
        .i_item  (eff_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

>>> hw/rtl/fcb_tint.sv
`timescale 1ns / 1ps
// Tint segment: texel times tint (stage 1), divide by 255 and clip test (stage 2).
// Depends on fcb_pkg.
module fcb_tint #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fcb_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  fcb_pkg::t_frag_in i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output fcb_pkg::t_tinted o_item
);
    import fcb_pkg::*;

    typedef struct packed {
        logic [3:0][15:0] prod;   // red, green, blue, alpha
        logic [2:0][7:0]  dest;
        logic [9:0]       x;
        logic [9:0]       y;
        logic             in_frame;
    } t_tint_s1;

    t_tint_s1 r_s1, n_s1;
    t_tinted  r_s2, n_s2;
    logic     r_v1, r_v2;
    logic     adv1, adv2;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_comb begin
        n_s1.prod[0]   = mul_bias(i_item.texel_red,   i_cfg.tint_red);
        n_s1.prod[1]   = mul_bias(i_item.texel_green, i_cfg.tint_green);
        n_s1.prod[2]   = mul_bias(i_item.texel_blue,  i_cfg.tint_blue);
        n_s1.prod[3]   = mul_bias(i_item.texel_alpha, i_cfg.tint_alpha);
        n_s1.dest[0]   = i_item.dest_red;
        n_s1.dest[1]   = i_item.dest_green;
        n_s1.dest[2]   = i_item.dest_blue;
        n_s1.x         = i_item.pixel_x;
        n_s1.y         = i_item.pixel_y;
        n_s1.in_frame  = ({3'd0, i_item.pixel_x} < 13'(FRAME_WIDTH))
                      && ({3'd0, i_item.pixel_y} < 13'(FRAME_HEIGHT));
    end

    always_comb begin
        n_s2.src[0] = div255(r_s1.prod[0]);
        n_s2.src[1] = div255(r_s1.prod[1]);
        n_s2.src[2] = div255(r_s1.prod[2]);
        n_s2.alpha  = div255(r_s1.prod[3]);
        n_s2.dest   = r_s1.dest;
        n_s2.x      = r_s1.x;
        n_s2.y      = r_s1.y;
        n_s2.keep   = r_s1.in_frame && (n_s2.alpha != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= n_s1;
        end
        if (adv2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_s2;

endmodule

>>> hw/rtl/fcb_effect.sv
`timescale 1ns / 1ps
// Effect segment: per-mode effect colour (stage 3), rounding divide in multiply mode (stage 4).
// Depends on fcb_pkg.
module fcb_effect (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_mode,
    input  logic             i_valid,
    output logic             o_ready,
    input  fcb_pkg::t_tinted i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output fcb_pkg::t_effect o_item
);
    import fcb_pkg::*;

    typedef struct packed {
        logic [2:0][15:0] raw;
        logic [7:0]       alpha;
        logic [2:0][7:0]  dest;
        logic [9:0]       x;
        logic [9:0]       y;
        logic             keep;
    } t_eff_s1;

    t_eff_s1 r_s1, n_s1;
    t_effect r_s2, n_s2;
    logic    r_v1, r_v2;
    logic    adv1, adv2;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_comb begin
        logic [8:0] sum;
        sum = 9'd0;
        for (int c = 0; c < 3; c++) begin
            sum = {1'b0, i_item.dest[c]} + {1'b0, i_item.src[c]};
            case (i_mode)
                MODE_ADDITIVE: n_s1.raw[c] = {8'h00, (sum[8] ? FULL_SCALE : sum[7:0])};
                MODE_MULTIPLY: n_s1.raw[c] = mul_bias(i_item.dest[c], i_item.src[c]);
                default:       n_s1.raw[c] = {8'h00, i_item.src[c]};
            endcase
        end
        n_s1.alpha = i_item.alpha;
        n_s1.dest  = i_item.dest;
        n_s1.x     = i_item.x;
        n_s1.y     = i_item.y;
        n_s1.keep  = i_item.keep;
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s2.eff[c] = (i_mode == MODE_MULTIPLY) ? div255(r_s1.raw[c]) : r_s1.raw[c][7:0];
        end
        n_s2.alpha = r_s1.alpha;
        n_s2.dest  = r_s1.dest;
        n_s2.x     = r_s1.x;
        n_s2.y     = r_s1.y;
        n_s2.keep  = r_s1.keep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= n_s1;
        end
        if (adv2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_s2;

endmodule

>>> hw/rtl/fcb_mix.sv
`timescale 1ns / 1ps
// Mix segment: alpha-weighted products (stage 5), sum, divide, select (stage 6).
// Stage 6 is the output register. Depends on fcb_pkg.
module fcb_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_mode,
    input  logic               i_valid,
    output logic               o_ready,
    input  fcb_pkg::t_effect   i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output fcb_pkg::t_frag_out o_item
);
    import fcb_pkg::*;

    typedef struct packed {
        logic [2:0][15:0] p_eff;   // e * A
        logic [2:0][15:0] p_dst;   // d * (255 - A)
        logic [2:0][7:0]  eff;
        logic [7:0]       alpha;
        logic [9:0]       x;
        logic [9:0]       y;
        logic             keep;
    } t_mix_s1;

    t_mix_s1   r_s1, n_s1;
    t_frag_out r_s2, n_s2;
    logic      r_v1, r_v2;
    logic      adv1, adv2;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_comb begin
        logic [7:0] inv_a;
        inv_a = FULL_SCALE - i_item.alpha;
        for (int c = 0; c < 3; c++) begin
            n_s1.p_eff[c] = {8'h00, i_item.eff[c]} * {8'h00, i_item.alpha};
            n_s1.p_dst[c] = {8'h00, i_item.dest[c]} * {8'h00, inv_a};
        end
        n_s1.eff   = i_item.eff;
        n_s1.alpha = i_item.alpha;
        n_s1.x     = i_item.x;
        n_s1.y     = i_item.y;
        n_s1.keep  = i_item.keep;
    end

    always_comb begin
        logic [16:0]     sum;
        logic [2:0][7:0] mixed;
        logic [2:0][7:0] col;
        logic            opaque;
        sum    = 17'd0;
        opaque = (i_mode == MODE_OPAQUE);
        for (int c = 0; c < 3; c++) begin
            // convex mix stays below 2^16
            sum      = {1'b0, r_s1.p_eff[c]} + {1'b0, r_s1.p_dst[c]} + {1'b0, ROUND_BIAS};
            mixed[c] = div255(sum[15:0]);
            col[c]   = r_s1.keep ? (opaque ? r_s1.eff[c] : mixed[c]) : 8'd0;
        end
        n_s2.write_enable = r_s1.keep;
        n_s2.out_x        = r_s1.x;
        n_s2.out_y        = r_s1.y;
        n_s2.out_red      = col[0];
        n_s2.out_green    = col[1];
        n_s2.out_blue     = col[2];
        n_s2.out_alpha    = r_s1.keep ? (opaque ? r_s1.alpha : FULL_SCALE) : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= n_s1;
        end
        if (adv2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_s2;

endmodule

>>> hw/rtl/fcb_checker.sv
`timescale 1ns / 1ps
// Port-level checker for fragment_color_blend_core, bound to the top level.
// Depends on fcb_pkg and fragment_color_blend_core_macros.svh.
`include "fragment_color_blend_core_macros.svh"

module fcb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input fcb_pkg::t_frag_out o_out_item
);
    import fcb_pkg::*;

    `FCB_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "out item withdrawn before taken")

    `FCB_ASSERT_NEXT(a_out_item_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_item), "out item changed while stalled")

    `FCB_ASSERT_NOW(a_skip_is_blank, i_clk, i_rst_n, o_out_valid && !o_out_item.write_enable, (o_out_item.out_red == 8'd0) && (o_out_item.out_green == 8'd0) && (o_out_item.out_blue == 8'd0) && (o_out_item.out_alpha == 8'd0), "skipped write carries colour")

    `FCB_ASSERT_NOW(a_write_has_alpha, i_clk, i_rst_n, o_out_valid && o_out_item.write_enable, o_out_item.out_alpha != 8'd0, "write with zero alpha")

endmodule

bind fragment_color_blend_core fcb_checker u_fcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

>>> tb/tb_fragment_color_blend_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for fragment_color_blend_core: fragments in, write requests out,
// each write predicted from the tint and blend mode registers. Depends on fcb_pkg and the core.
module tb_fragment_color_blend_core;
    import fcb_pkg::*;

    localparam int          FRAME_W        = 1024;
    localparam int          FRAME_H        = 1024;
    localparam int          RANDOM_PHASES  = 11;
    localparam int          ITEMS_PER_PHASE = 100;
    localparam int          SETTLE_CYCLES  = 10;     // pipe is 6 deep, a few spare
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // Holds the tint/mode registers as the core should see them, predicts the
    // write request for each fragment and checks what comes out, oldest first.
    class fcb_blend_scoreboard;
        logic [7:0]  tint_r, tint_g, tint_b, tint_a;
        logic [1:0]  mode;
        int unsigned frame_w, frame_h;
        t_frag_out   pending_writes[$];
        int          errors;
        int          fragments;
        int          discarded;
        int          written[4];

        function new(int unsigned w, int unsigned h);
            frame_w = w;
            frame_h = h;
            tint_r  = FULL_SCALE;
            tint_g  = FULL_SCALE;
            tint_b  = FULL_SCALE;
            tint_a  = FULL_SCALE;
            mode    = MODE_OPAQUE;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_TINT_RED:   tint_r = value[7:0];
                REG_TINT_GREEN: tint_g = value[7:0];
                REG_TINT_BLUE:  tint_b = value[7:0];
                REG_TINT_ALPHA: tint_a = value[7:0];
                REG_BLEND_MODE: mode   = value[1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_TINT_RED:   return {24'd0, tint_r};
                REG_TINT_GREEN: return {24'd0, tint_g};
                REG_TINT_BLUE:  return {24'd0, tint_b};
                REG_TINT_ALPHA: return {24'd0, tint_a};
                REG_BLEND_MODE: return {30'd0, mode};
                default:        return 32'd0;
            endcase
        endfunction

        // (a*b + 127) / 255
        function logic [7:0] round_mul(logic [7:0] a, logic [7:0] b);
            int unsigned ua, ub;
            ua = 32'(a);
            ub = 32'(b);
            return 8'((ua * ub + 127) / 255);
        endfunction

        // per-channel effect, then mixed over the destination by alpha
        function logic [7:0] blend_chan(logic [7:0] dst, logic [7:0] src, logic [7:0] alpha);
            int unsigned d, e, a, s;
            d = 32'(dst);
            a = 32'(alpha);
            s = 32'(src);
            case (mode)
                MODE_ALPHA:    e = s;
                MODE_ADDITIVE: e = (d + s > 255) ? 255 : d + s;
                default:       e = 32'(round_mul(dst, src));
            endcase
            return 8'((e * a + d * (255 - a) + 127) / 255);
        endfunction

        function t_frag_out predict_write(t_frag_in f);
            t_frag_out  w;
            logic [7:0] sr, sg, sb, sa;
            sr = round_mul(f.texel_red, tint_r);
            sg = round_mul(f.texel_green, tint_g);
            sb = round_mul(f.texel_blue, tint_b);
            sa = round_mul(f.texel_alpha, tint_a);
            w = '0;
            w.out_x = f.pixel_x;
            w.out_y = f.pixel_y;
            if (sa != 0 && f.pixel_x < frame_w && f.pixel_y < frame_h) begin
                w.write_enable = 1'b1;
                if (mode == MODE_OPAQUE) begin
                    w.out_red   = sr;
                    w.out_green = sg;
                    w.out_blue  = sb;
                    w.out_alpha = sa;
                end else begin
                    w.out_red   = blend_chan(f.dest_red, sr, sa);
                    w.out_green = blend_chan(f.dest_green, sg, sa);
                    w.out_blue  = blend_chan(f.dest_blue, sb, sa);
                    w.out_alpha = FULL_SCALE;
                end
            end
            return w;
        endfunction

        function void note_fragment(t_frag_in f);
            t_frag_out w;
            w = predict_write(f);
            pending_writes = {pending_writes, w};
            fragments++;
            if (w.write_enable) written[mode]++;
            else discarded++;
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        task check_write(t_frag_out got);
            t_frag_out want;
            if (pending_writes.size() == 0) begin
                report($sformatf("unexpected write request 0x%0h", got));
                return;
            end
            want = pending_writes.pop_front();
            check_field("write_enable", 32'(got.write_enable), 32'(want.write_enable));
            check_field("out_x", 32'(got.out_x), 32'(want.out_x));
            check_field("out_y", 32'(got.out_y), 32'(want.out_y));
            check_field("out_red", 32'(got.out_red), 32'(want.out_red));
            check_field("out_green", 32'(got.out_green), 32'(want.out_green));
            check_field("out_blue", 32'(got.out_blue), 32'(want.out_blue));
            check_field("out_alpha", 32'(got.out_alpha), 32'(want.out_alpha));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_frag_in            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_frag_out           o_out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    fcb_blend_scoreboard sb;
    int unsigned         idle_cycles;
    int                  settings_seen;
    int                  burst_left;

    // receiver stall pattern state
    int                  stall_style;
    int                  stall_left;
    int                  stall_period;
    int                  stall_low;
    int unsigned         rx_tick;

    fragment_color_blend_core #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitors: sample at the rising edge, before the core's registers move.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_fragment(i_in_item);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_write(o_out_item);
    end

    // Watchdog: any handshake on either channel or the register port resets it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            sb.report("watchdog: no progress, run abandoned");
            $display("tb_fragment_color_blend_core: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver back-pressure: styles are redrawn whenever stall_left runs out -
    // always ready, a fixed low/high period, or random with two densities.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style  = $urandom_range(0, 3);
            stall_left   = $urandom_range(64, 256);
            stall_period = $urandom_range(2, 16);
            stall_low    = $urandom_range(1, stall_period - 1);
        end
        stall_left--;
        rx_tick++;
        case (stall_style)
            0:       i_out_ready = 1'b1;
            1:       i_out_ready = (rx_tick % stall_period) >= stall_low;
            2:       i_out_ready = $urandom_range(0, 3) != 0;
            default: i_out_ready = $urandom_range(0, 1) != 0;
        endcase
    end

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input bit is_write, input logic [2:0] idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (is_write) sb.set_reg(idx, wdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Load a full setting, poke an unmapped index (must be ignored), read all back.
    // Upper data bits are random so the field masking gets exercised.
    task automatic load_setting(input logic [7:0] tr, input logic [7:0] tg,
                                input logic [7:0] tb, input logic [7:0] ta,
                                input logic [1:0] md);
        logic [31:0] rd;
        logic [2:0]  idx;
        apb_transfer(1'b1, REG_TINT_RED,   ($urandom & 32'hFFFF_FF00) | tr, rd);
        apb_transfer(1'b1, REG_TINT_GREEN, ($urandom & 32'hFFFF_FF00) | tg, rd);
        apb_transfer(1'b1, REG_TINT_BLUE,  ($urandom & 32'hFFFF_FF00) | tb, rd);
        apb_transfer(1'b1, REG_TINT_ALPHA, ($urandom & 32'hFFFF_FF00) | ta, rd);
        apb_transfer(1'b1, REG_BLEND_MODE, ($urandom & 32'hFFFF_FFFC) | md, rd);
        apb_transfer(1'b1, REG_BLEND_MODE + 3'($urandom_range(1, 3)), $urandom, rd);
        for (int i = REG_TINT_RED; i <= REG_BLEND_MODE; i++) begin
            idx = 3'(i);
            apb_transfer(1'b0, idx, 32'd0, rd);
            if (rd !== sb.reg_value(idx))
                sb.report($sformatf("register %0d reads 0x%0h want 0x%0h",
                                    idx, rd, sb.reg_value(idx)));
        end
        settings_seen++;
    endtask

    // Present one fragment and hold it until the core takes it.
    task automatic drive_fragment(input t_frag_in f);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item  = f;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic sender_gap(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Drain the pipe before touching the registers.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Texel alpha is skewed towards zero, full and tiny values so the
    // discard path and the rounding edges turn up often.
    function automatic t_frag_in random_fragment();
        t_frag_in    f;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        f   = raw[$bits(t_frag_in)-1:0];
        case ($urandom_range(0, 7))
            0:       f.texel_alpha = 8'd0;
            1:       f.texel_alpha = FULL_SCALE;
            2:       f.texel_alpha = 8'($urandom_range(1, 3));
            default: ;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] pick_tint();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return FULL_SCALE;
            2:       return 8'd1;
            3:       return 8'd254;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_stream(input int n, input bit gaps);
        for (int i = 0; i < n; i++) begin
            if (gaps && burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                sender_gap($urandom_range(0, 12));
            end
            drive_fragment(random_fragment());
            if (burst_left > 0) burst_left--;
        end
    endtask

    initial begin
        sb           = new(FRAME_W, FRAME_H);
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_out_ready  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idle_cycles  = 0;
        burst_left   = 0;
        stall_left   = 0;
        rx_tick      = 0;
        settings_seen = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: the same handful of fragments under every blend mode -
        // full white on black, zero alpha at the far corner, alpha of one,
        // mixed extremes and a mid-grey just short of full alpha.
        for (int m = MODE_OPAQUE; m <= MODE_MULTIPLY; m++) begin
            load_setting(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, 2'(m));
            drive_fragment('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 10'd0, 10'd0});
            drive_fragment('{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                             10'd1023, 10'd1023});
            drive_fragment('{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF, 8'h80, 8'h00,
                             10'd1023, 10'd0});
            drive_fragment('{8'h00, 8'hFF, 8'h7F, 8'h80, 8'hFF, 8'hFF, 8'hFF,
                             10'd0, 10'd1023});
            drive_fragment('{8'h80, 8'h80, 8'h80, 8'hFE, 8'h7F, 8'h01, 8'hFE,
                             10'd512, 10'd511});
            wait_drained();
        end

        // Tint rounding: alpha one under a half tint rounds to zero and is
        // discarded, full alpha comes out at the tint.
        load_setting(8'd0, 8'd127, FULL_SCALE, 8'd127, MODE_ALPHA);
        drive_fragment('{8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h40, 8'h40, 8'h40, 10'd3, 10'd5});
        drive_fragment('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h40, 8'h40, 8'h40, 10'd5, 10'd3});
        wait_drained();

        // Random phases, each under its own setting; modes rotate, the first
        // phase uses full tint and the second zero colour tint.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       load_setting(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, 2'(p));
                1:       load_setting(8'd0, 8'd0, 8'd0, FULL_SCALE, 2'(p));
                default: load_setting(pick_tint(), pick_tint(), pick_tint(), pick_tint(),
                                      2'(p));
            endcase
            // every third phase streams flat out with no sender gaps
            send_stream(ITEMS_PER_PHASE, (p % 3) != 2);
            wait_drained();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d write requests never arrived", sb.pending()));

        $display("covered %0d fragments under %0d register settings, %0d discarded",
                 sb.fragments, settings_seen, sb.discarded);
        $display("writes per mode: opaque %0d alpha %0d additive %0d multiply %0d",
                 sb.written[MODE_OPAQUE], sb.written[MODE_ALPHA],
                 sb.written[MODE_ADDITIVE], sb.written[MODE_MULTIPLY]);
        if (sb.errors == 0) begin
            $display("tb_fragment_color_blend_core: PASS");
        end else begin
            $display("tb_fragment_color_blend_core: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fcb_pkg.sv
hw/rtl/fcb_tint.sv
hw/rtl/fcb_effect.sv
hw/rtl/fcb_mix.sv
hw/rtl/fragment_color_blend_core.sv
hw/rtl/fcb_checker.sv
tb/tb_fragment_color_blend_core.sv
